>>> src/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants and the controller state type of the randomized quicksort.
// ----------------------------------------------------------------------------
package rqs_pkg;

  // Data word and store geometry
  localparam int DATA_W       = 32;
  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;

  // Range stack: one entry per pending range, {hi, lo}
  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH) + 1;
  localparam int STK_W       = 2 * IDX_W;

  // Pivot source: 16-bit Galois LFSR
  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam int          DIV_CNT_W = $clog2(LFSR_W);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_INIT     = 16'h0002,
    ST_POP      = 16'h0004,
    ST_POP_WAIT = 16'h0008,
    ST_DIV      = 16'h0010,
    ST_SWP_RD_A = 16'h0020,
    ST_SWP_RD_B = 16'h0040,
    ST_SWP_WR_A = 16'h0080,
    ST_SWP_WR_B = 16'h0100,
    ST_PIV_RD   = 16'h0200,
    ST_PIV_WAIT = 16'h0400,
    ST_PART_RD  = 16'h0800,
    ST_PART_CMP = 16'h1000,
    ST_PUSH_LO  = 16'h2000,
    ST_PUSH_HI  = 16'h4000,
    ST_OUT      = 16'h8000
  } state_t;

  // One step of the Galois LFSR
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

>>> src/randomized_quicksort.sv
// ----------------------------------------------------------------------------
// randomized_quicksort
// Loads signed words into a store, sorts them in place by quicksort with
// Lomuto partitioning and a random pivot, then streams them out ascending.
// ----------------------------------------------------------------------------
// Words load at one per cycle while busy is low; up to 64 are held and any
// beyond that are dropped. The word marked in_final_item starts the sort,
// and busy stays high until the last sorted word has been shown. The sort
// runs over a single element memory with one read and one write port and a
// registered read: each partition picks its pivot by a bit-serial modulo,
// swaps it to the top of the range, then reads and compares each element
// scanned and swaps each one moved. Results then stream out one per cycle
// on out_valid and cannot be stalled; the final one carries out_final_result.
// A new set may start loading in the cycle that shows the final result.
// ----------------------------------------------------------------------------
module randomized_quicksort (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rqs_pkg::DATA_W-1:0]  in_value,
  input  logic                               in_final_item,
  output logic                               out_valid,
  output logic signed [rqs_pkg::DATA_W-1:0]  out_sorted_value,
  output logic                               out_final_result
);
  import rqs_pkg::*;

  // Memories
  logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [STK_W-1:0]  stk_mem  [STACK_DEPTH];

  logic [DATA_W-1:0] mem_rdata_r;
  logic [STK_W-1:0]  stk_rdata_r;

  logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
  logic              mem_wr_en;
  logic [DATA_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]  stk_rd_addr, stk_wr_addr;
  logic              stk_wr_en;
  logic [STK_W-1:0]  stk_wr_data;

  // Control and datapath registers
  state_t                 state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SP_W-1:0]        sp_r, sp_nxt;
  logic [LFSR_W-1:0]      lfsr_r, lfsr_nxt;
  logic [IDX_W-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]       j_r, j_nxt, st_r, st_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]       swap_a_r, swap_a_nxt, swap_b_r, swap_b_nxt;
  logic [DATA_W-1:0]      tmp_r, tmp_nxt, pivot_r, pivot_nxt;
  logic [LFSR_W-1:0]      dq_r, dq_nxt;
  logic [IDX_W-1:0]       rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_final_r, out_final_nxt;

  // Scratch
  logic [IDX_W:0]         trial;
  logic [IDX_W-1:0]       rem_new;
  logic [IDX_W-1:0]       stk_lo, stk_hi;
  logic [IDX_W-1:0]       last_idx;
  logic                   le_pivot;

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = mem_rdata_r;
  assign out_final_result = out_final_r;

  assign stk_lo   = stk_rdata_r[IDX_W-1:0];
  assign stk_hi   = stk_rdata_r[STK_W-1:IDX_W];
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign le_pivot = ($signed(mem_rdata_r) <= $signed(pivot_r));

  // Restoring modulo step: shift in one dividend bit, subtract if it fits
  assign trial   = {rem_r, dq_r[LFSR_W-1]};
  assign rem_new = (trial >= {1'b0, dvs_r}) ? IDX_W'(trial - {1'b0, dvs_r})
                                            : trial[IDX_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    lfsr_nxt      = lfsr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    st_nxt        = st_r;
    k_nxt         = k_r;
    swap_a_nxt    = swap_a_r;
    swap_b_nxt    = swap_b_r;
    tmp_nxt       = tmp_r;
    pivot_nxt     = pivot_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = 1'b0;
    out_final_nxt = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    stk_rd_addr   = '0;
    stk_wr_en     = 1'b0;
    stk_wr_addr   = '0;
    stk_wr_data   = '0;

    unique case (state_r)
      // Load words; the final one starts the sort
      ST_IDLE: begin
        if (start) begin
          if (count_r < CNT_W'(MAX_ELEMENTS)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = count_r[IDX_W-1:0];
            mem_wr_data = in_value;
            count_nxt   = count_r + CNT_W'(1);
          end
          if (in_final_item) begin
            state_nxt = ST_INIT;
          end
        end
      end

      // Push the whole set, or go straight to output for a single word
      ST_INIT: begin
        sp_nxt = '0;
        k_nxt  = '0;
        if (count_r >= CNT_W'(2)) begin
          stk_wr_en   = 1'b1;
          stk_wr_addr = '0;
          stk_wr_data = {last_idx, {IDX_W{1'b0}}};
          sp_nxt      = SP_W'(1);
          state_nxt   = ST_POP;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_OUT;
        end else begin
          stk_rd_addr = IDX_W'(sp_r - SP_W'(1));
          sp_nxt      = sp_r - SP_W'(1);
          state_nxt   = ST_POP_WAIT;
        end
      end

      // Range popped: if lo < hi, draw a random number and start the modulo
      ST_POP_WAIT: begin
        if (stk_lo >= stk_hi) begin
          state_nxt = ST_POP;
        end else begin
          lo_nxt    = stk_lo;
          hi_nxt    = stk_hi;
          lfsr_nxt  = lfsr_step(lfsr_r);
          dq_nxt    = lfsr_step(lfsr_r);
          rem_nxt   = '0;
          dvs_nxt   = stk_hi - stk_lo;
          dcnt_nxt  = DIV_CNT_W'(LFSR_W - 1);
          state_nxt = ST_DIV;
        end
      end

      // Pivot index = lo + rand mod (hi - lo), one bit per cycle
      ST_DIV: begin
        rem_nxt  = rem_new;
        dq_nxt   = dq_r << 1;
        dcnt_nxt = dcnt_r - DIV_CNT_W'(1);
        if (dcnt_r == '0) begin
          swap_a_nxt = lo_r + rem_new;
          swap_b_nxt = hi_r;
          ret_nxt    = ST_PIV_RD;
          state_nxt  = ST_SWP_RD_A;
        end
      end

      // Swap two entries: read a, read b, write a, write b
      ST_SWP_RD_A: begin
        mem_rd_addr = swap_a_r;
        state_nxt   = ST_SWP_RD_B;
      end
      ST_SWP_RD_B: begin
        mem_rd_addr = swap_b_r;
        tmp_nxt     = mem_rdata_r;
        state_nxt   = ST_SWP_WR_A;
      end
      ST_SWP_WR_A: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = swap_a_r;
        mem_wr_data = mem_rdata_r;
        state_nxt   = ST_SWP_WR_B;
      end
      ST_SWP_WR_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = swap_b_r;
        mem_wr_data = tmp_r;
        state_nxt   = ret_r;
      end

      // Fetch the pivot now parked at hi
      ST_PIV_RD: begin
        mem_rd_addr = hi_r;
        state_nxt   = ST_PIV_WAIT;
      end
      ST_PIV_WAIT: begin
        pivot_nxt = mem_rdata_r;
        j_nxt     = lo_r;
        st_nxt    = lo_r;
        state_nxt = ST_PART_RD;
      end

      // Lomuto scan over lo .. hi-1
      ST_PART_RD: begin
        if (j_r == hi_r) begin
          swap_a_nxt = hi_r;
          swap_b_nxt = st_r;
          ret_nxt    = ST_PUSH_LO;
          state_nxt  = ST_SWP_RD_A;
        end else begin
          mem_rd_addr = j_r;
          state_nxt   = ST_PART_CMP;
        end
      end
      ST_PART_CMP: begin
        j_nxt     = j_r + IDX_W'(1);
        state_nxt = ST_PART_RD;
        if (le_pivot) begin
          st_nxt = st_r + IDX_W'(1);
          if (j_r != st_r) begin
            swap_a_nxt = j_r;
            swap_b_nxt = st_r;
            ret_nxt    = ST_PART_RD;
            state_nxt  = ST_SWP_RD_A;
          end
        end
      end

      // Push sub-ranges of 2+ words if the stack has room; st_r is the pivot
      ST_PUSH_LO: begin
        if ((st_r > lo_r + IDX_W'(1)) && (sp_r < SP_W'(STACK_DEPTH))) begin
          stk_wr_en   = 1'b1;
          stk_wr_addr = sp_r[IDX_W-1:0];
          stk_wr_data = {st_r - IDX_W'(1), lo_r};
          sp_nxt      = sp_r + SP_W'(1);
        end
        state_nxt = ST_PUSH_HI;
      end
      ST_PUSH_HI: begin
        if (({1'b0, st_r} + 7'(1) < {1'b0, hi_r}) && (sp_r < SP_W'(STACK_DEPTH))) begin
          stk_wr_en   = 1'b1;
          stk_wr_addr = sp_r[IDX_W-1:0];
          stk_wr_data = {hi_r, st_r + IDX_W'(1)};
          sp_nxt      = sp_r + SP_W'(1);
        end
        state_nxt = ST_POP;
      end

      // Stream out one word per cycle; the registered read data lines up with out_valid
      ST_OUT: begin
        mem_rd_addr   = k_r;
        out_valid_nxt = 1'b1;
        if (k_r == last_idx) begin
          out_final_nxt = 1'b1;
          count_nxt     = '0;
          sp_nxt        = '0;
          state_nxt     = ST_IDLE;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      count_r     <= '0;
      sp_r        <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      out_final_r <= out_final_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    j_r      <= j_nxt;
    st_r     <= st_nxt;
    k_r      <= k_nxt;
    swap_a_r <= swap_a_nxt;
    swap_b_r <= swap_b_nxt;
    tmp_r    <= tmp_nxt;
    pivot_r  <= pivot_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    dcnt_r   <= dcnt_nxt;
  end

  // Element memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      elem_mem[mem_wr_addr] <= mem_wr_data;
    end
    mem_rdata_r <= elem_mem[mem_rd_addr];
  end

  // Range stack memory
  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    stk_rdata_r <= stk_mem[stk_rd_addr];
  end

endmodule

>>> bench/tb_randomized_quicksort.sv
// ----------------------------------------------------------------------------
// tb_randomized_quicksort
// Self-checking bench for the randomized quicksort block. Words are loaded in
// random bursts. A behavioral model holds its own copy of the element store
// and computes the ascending order at every closing word. A monitor compares
// each streamed word with the oldest expected one, value and final flag.
// ----------------------------------------------------------------------------
module tb_randomized_quicksort;
  timeunit 1ns;
  timeprecision 1ps;

  import rqs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int TOTAL_WORDS  = 265;
  localparam int REPORT_MAX   = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Ways of filling a random set
  typedef enum int {
    FILL_ANY,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_RISING,
    FILL_FALLING
  } fill_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_result;
  } sorted_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_final_item = 1'b0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_result;

  // Model state: words held for the set being loaded
  logic signed [DATA_W-1:0] held_words [MAX_ELEMENTS];
  int                       held_count = 0;
  sorted_word_t             expected_words [$];

  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           words_sent = 0;
  int           burst_left = 0;
  sorted_word_t seen_word;
  sorted_word_t want_word;

  randomized_quicksort dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_result (out_final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one word; on the closing word, queue the held set in ascending order
  task automatic predict_sorted_set(input logic signed [DATA_W-1:0] value,
                                    input logic final_item);
    logic signed [DATA_W-1:0] ordered [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] key;
    sorted_word_t             word;
    int                       i;
    int                       j;
    if (held_count < MAX_ELEMENTS) begin
      held_words[held_count] = value;
      held_count++;
    end
    if (final_item) begin
      // insertion sort on signed values
      for (i = 0; i < held_count; i++) begin
        key = held_words[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      for (i = 0; i < held_count; i++) begin
        word.sorted_value = ordered[i];
        word.final_result = (i == held_count - 1);
        expected_words.push_back(word);
      end
      held_count = 0;
    end
  endtask

  // Drive one word at the falling edge and hold it until busy is seen low
  task automatic send_word(input logic signed [DATA_W-1:0] value,
                           input logic final_item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      start = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start = 1'b1;
    in_value = value;
    in_final_item = final_item;
    do @(posedge clk); while (busy);
    predict_sorted_set(value, final_item);
    words_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input fill_mode_t mode,
                                                          input int pos,
                                                          input logic signed [DATA_W-1:0] base);
    logic signed [DATA_W-1:0] v;
    case (mode)
      FILL_NARROW: begin
        v = $signed($urandom_range(0, 6)) - 3;
      end
      FILL_EXTREME: begin
        case ($urandom_range(0, 6))
          0: v = VAL_MIN;
          1: v = VAL_MIN + 1;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = VAL_MAX - 1;
          default: v = VAL_MAX;
        endcase
      end
      FILL_RISING: begin
        v = base + pos;
      end
      FILL_FALLING: begin
        v = base - pos;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // Sets of one word, including both extremes
  task automatic test_single_word();
    send_word(VAL_MIN, 1'b1);
    send_word(0, 1'b1);
    send_word(VAL_MAX, 1'b1);
  endtask

  // Two-word set out of order, then the signed extremes mixed
  task automatic test_extremes();
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b1);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b0);
    send_word(VAL_MIN + 1, 1'b0);
    send_word(VAL_MAX - 1, 1'b1);
  endtask

  // Repeated keys, an all-equal set and a descending run
  task automatic test_duplicates();
    int i;
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    send_word(-5, 1'b0);
    send_word(5, 1'b0);
    send_word(-5, 1'b0);
    send_word(5, 1'b1);
    send_word(7, 1'b0);
    send_word(7, 1'b1);
    for (i = 4; i >= 0; i--) begin
      send_word(i, i == 0);
    end
  endtask

  // Exactly a full store, then a set that overflows it; the extra words drop
  task automatic test_store_full();
    int                       i;
    int                       n;
    logic signed [DATA_W-1:0] base;
    base = $urandom;
    for (i = 0; i < MAX_ELEMENTS; i++) begin
      send_word(base - i, i == MAX_ELEMENTS - 1);
    end
    n = MAX_ELEMENTS + $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      send_word($urandom, i == n - 1);
    end
  endtask

  // Random sets, mostly small, with the odd full drain in between
  task automatic test_random_sets();
    fill_mode_t               mode;
    logic signed [DATA_W-1:0] base;
    int                       n;
    int                       i;
    while (words_sent < TOTAL_WORDS) begin
      mode = fill_mode_t'($urandom_range(0, 4));
      base = $urandom;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        send_word(pick_value(mode, i, base), i == n - 1);
      end
      if ($urandom_range(0, 5) == 0) begin
        wait_results_drained();
      end
    end
  endtask

  // Result monitor: each streamed word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen_word.sorted_value = out_sorted_value;
      seen_word.final_result = out_final_result;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected word: value %0d final %0b",
                   seen_word.sorted_value, seen_word.final_result);
        end
      end else begin
        want_word = expected_words.pop_front();
        if (seen_word.sorted_value !== want_word.sorted_value ||
            seen_word.final_result !== want_word.final_result) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("word mismatch: expected value %0d final %0b, got value %0d final %0b",
                     want_word.sorted_value, want_word.final_result,
                     seen_word.sorted_value, seen_word.final_result);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_word();
    test_extremes();
    test_duplicates();
    // let the block go fully idle before the next load
    wait_results_drained();
    test_store_full();
    test_random_sets();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/rqs_pkg.sv
src/randomized_quicksort.sv
bench/tb_randomized_quicksort.sv
